// File: rtl/fexp_pkg.sv
`default_nettype none

package fexp_pkg;

    localparam int INPUT_FRAC_BITS_DEF  = 20;
    localparam int ADJUST_FRAC_BITS_DEF = 23;

    localparam int IDX_BITS   = 8;
    localparam int ROM_DEPTH  = 1 << IDX_BITS;
    localparam int FRAC_W     = 20;
    localparam int EXPO_W     = 11;
    localparam int MANT_W     = 52;
    localparam int PROD_W     = 53;

    localparam logic [21:0] EXP_SCALE = 22'd1512775;
    localparam logic [30:0] EXP_BIAS  = 31'd1072632447;
    localparam logic [31:0] T_OVF     = 32'h7FF0_0000;
    localparam logic [63:0] RES_INF   = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] RES_ZERO  = 64'h0;
    localparam logic [11:0] EXPO_MAX  = 12'h7FF;

    localparam longint unsigned DEC_ONE = 64'd1000000000;
    localparam longint unsigned DEC_TWO = 64'd2000000000;

    typedef enum logic [1:0] {
        KIND_NORM,
        KIND_ZERO,
        KIND_INF
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [EXPO_W-1:0]   expo;
    } t_ctl;

    localparam int unsigned ADJ_DEC [ROM_DEPTH] = '{
        1040389835, 1039159306, 1037945888, 1036749401, 1035569671, 1034406528,
        1033259801, 1032129324, 1031014933, 1029916467, 1028833767, 1027766676,
        1026715040, 1025678708, 1024657530, 1023651359, 1022660049, 1021683458,
        1020721446, 1019773873, 1018840604, 1017921503, 1017016438, 1016125279,
        1015247897, 1014384165, 1013533958, 1012697153, 1011873629, 1011063266,
        1010265947, 1009481555, 1008709975, 1007951096, 1007204805, 1006470993,
        1005749552, 1005040376, 1004343358, 1003658397, 1002985389, 1002324233,
        1001674831, 1001037085, 1000410897,  999796173,  999192819,  998600742,
         998019851,  997450055,  996891266,  996343396,  995806358,  995280068,
         994764440,  994259393,  993764844,  993280711,  992806917,  992343381,
         991890026,  991446776,  991013555,  990590289,  990176903,  989773325,
         989379484,  988995309,  988620729,  988255677,  987900083,  987553882,
         987217006,  986889390,  986570970,  986261682,  985961463,  985670251,
         985387985,  985114604,  984850048,  984594259,  984347178,  984108748,
         983878911,  983657613,  983444797,  983240409,  983044394,  982856701,
         982677276,  982506066,  982343022,  982188091,  982041225,  981902373,
         981771487,  981648519,  981533421,  981426146,  981326648,  981234880,
         981150798,  981074356,  981005511,  980944219,  980890437,  980844122,
         980805232,  980773726,  980749562,  980732700,  980723100,  980720722,
         980725528,  980737478,  980756534,  980782660,  980815817,  980855968,
         980903079,  980955475,  981017942,  981085714,  981160303,  981241675,
         981329796,  981424634,  981526154,  981634325,  981749114,  981870489,
         981998419,  982132873,  982273820,  982421229,  982575072,  982735318,
         982901937,  983074902,  983254183,  983439752,  983631582,  983829644,
         984033912,  984244358,  984460956,  984683681,  984912505,  985147403,
         985388349,  985635320,  985888290,  986147234,  986412128,  986682949,
         986959673,  987242277,  987530737,  987825031,  988125136,  988431030,
         988742691,  989060098,  989383229,  989712063,  990046579,  990386756,
         990732574,  991084012,  991441052,  991803672,  992171854,  992545578,
         992924825,  993309578,  993699816,  994095522,  994496677,  994903265,
         995315266,  995732665,  996155442,  996583582,  997017068,  997455883,
         997900010,  998349434,  998804138,  999264107,  999729325, 1000199776,
        1000675446, 1001156319, 1001642381, 1002133617, 1002630011, 1003131551,
        1003638222, 1004150010, 1004666901, 1005188881, 1005715938, 1006248058,
        1006785227, 1007327434, 1007874665, 1008426907, 1008984149, 1009546377,
        1010113581, 1010685747, 1011262865, 1011844922, 1012431907, 1013023808,
        1013620615, 1014222317, 1014828902, 1015440360, 1016056681, 1016677853,
        1017303866, 1017934711, 1018570378, 1019210855, 1019856135, 1020506206,
        1021161060, 1021820687, 1022485078, 1023154224, 1023828116, 1024506745,
        1025190103, 1025878180, 1026570969, 1027268461, 1027970647, 1028677520,
        1029389072, 1030114973, 1030826088, 1031551630, 1032281819, 1033016650,
        1033756114, 1034500204, 1035248913, 1036002235, 1036760162, 1037522688,
        1038289806, 1039061509, 1039837792, 1040618648
    };

    // correction factor rounded to nearest, ties up
    function automatic logic [31:0] adj_entry(int idx, int frac_bits);
        longint unsigned v;
        v = longint'(ADJ_DEC[idx]);
        return 32'(((v << (frac_bits + 1)) + DEC_ONE) / DEC_TWO);
    endfunction

endpackage

`default_nettype wire

// File: rtl/fexp_if.sv
`default_nettype none

interface fexp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

interface fexp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;
    logic        overflow_flag;
    logic        underflow_flag;

    modport source (output valid, output result_bits, output overflow_flag,
                    output underflow_flag, input ready);
    modport sink   (input valid, input result_bits, input overflow_flag,
                    input underflow_flag, output ready);
endinterface

`default_nettype wire

// File: rtl/fast_exp_table_corrected.sv
// channel | dir | payload                                     | accepted when
// i_in    | in  | x_value (signed Q11.20)                     | valid && ready
// o_out   | out | result_bits, overflow_flag, underflow_flag  | valid && ready
//
// five register stages: scale multiply, bias add and range check, correction
// table read, correction multiply, normalise and pack into the output register
// one item per cycle sustained while o_out is ready; an accepted item moves through r_v1 to r_v5 to o_out.valid
// synchronous active-low reset empties every stage; payload registers keep data
// a stalled output holds its item; each stage takes a new item when it is empty
// or the stage after it moves on

`default_nettype none

module fast_exp_table_corrected #(
    parameter int INPUT_FRAC_BITS  = fexp_pkg::INPUT_FRAC_BITS_DEF,
    parameter int ADJUST_FRAC_BITS = fexp_pkg::ADJUST_FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fexp_in_if.sink     i_in,
    fexp_out_if.source  o_out
);

    localparam int PRW = fexp_pkg::PROD_W;
    localparam int SW  = ((INPUT_FRAC_BITS + 31 > PRW) ? INPUT_FRAC_BITS + 31 : PRW) + 1;
    localparam int TW  = SW - INPUT_FRAC_BITS;
    localparam int RW  = ADJUST_FRAC_BITS + 1;
    localparam int PW  = ADJUST_FRAC_BITS + 22;
    localparam int FW  = fexp_pkg::FRAC_W;
    localparam int EW  = fexp_pkg::EXPO_W;
    localparam int IB  = fexp_pkg::IDX_BITS;

    localparam logic signed [PRW-1:0] SCALE_S = PRW'(fexp_pkg::EXP_SCALE);
    localparam logic [SW-1:0] BIAS_SH = SW'(fexp_pkg::EXP_BIAS) << INPUT_FRAC_BITS;

    // correction table
    logic [RW-1:0] w_rom [fexp_pkg::ROM_DEPTH];

    for (genvar g = 0; g < fexp_pkg::ROM_DEPTH; g++) begin : g_rom
        assign w_rom[g] = RW'(fexp_pkg::adj_entry(g, ADJUST_FRAC_BITS));
    end

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic n_rdy1, n_rdy2, n_rdy3, n_rdy4, n_rdy5;

    logic signed [PRW-1:0] r_prod1;
    fexp_pkg::t_ctl        r_ctl2, r_ctl3, r_ctl4;
    logic [FW-1:0]         r_f2, r_f3;
    logic [RW-1:0]         r_rom3;
    logic [PW-1:0]         r_p4;
    logic [63:0]           r_bits5;
    logic                  r_ovf5, r_unf5;

    logic signed [PRW-1:0] n_prod;
    logic signed [SW-1:0]  n_sum;
    logic [TW-1:0]         n_t;
    fexp_pkg::t_ctl        n_ctl2;
    logic [PW-1:0]         n_p;
    logic [63:0]           n_bits;
    logic                  n_ovf, n_unf;

    assign n_rdy5 = !r_v5 || o_out.ready;
    assign n_rdy4 = !r_v4 || n_rdy5;
    assign n_rdy3 = !r_v3 || n_rdy4;
    assign n_rdy2 = !r_v2 || n_rdy3;
    assign n_rdy1 = !r_v1 || n_rdy2;

    assign i_in.ready = n_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (n_rdy1) r_v1 <= i_in.valid;
            if (n_rdy2) r_v2 <= r_v1;
            if (n_rdy3) r_v3 <= r_v2;
            if (n_rdy4) r_v4 <= r_v3;
            if (n_rdy5) r_v5 <= r_v4;
        end
    end

    // stage 1: exact scale product
    assign n_prod = PRW'(i_in.x_value) * SCALE_S;

    // stage 2: bias, truncate, range check
    always_comb begin
        n_sum = SW'(r_prod1) + $signed(BIAS_SH);
        n_t   = n_sum[SW-1:INPUT_FRAC_BITS];
        n_ctl2.expo = n_t[30:20];
        if (n_sum[SW-1]) begin
            n_ctl2.kind = fexp_pkg::KIND_ZERO;
        end else if (n_t >= TW'(fexp_pkg::T_OVF)) begin
            n_ctl2.kind = fexp_pkg::KIND_INF;
        end else if (n_t[30:20] == EW'(0)) begin
            n_ctl2.kind = fexp_pkg::KIND_ZERO;
        end else begin
            n_ctl2.kind = fexp_pkg::KIND_NORM;
        end
    end

    // stage 4: correction product
    assign n_p = PW'({1'b1, r_f3}) * PW'(r_rom3);

    fexp_pack #(
        .ADJUST_FRAC_BITS (ADJUST_FRAC_BITS)
    ) u_pack (
        .i_p           (r_p4),
        .i_ctl         (r_ctl4),
        .o_result_bits (n_bits),
        .o_overflow    (n_ovf),
        .o_underflow   (n_unf)
    );

    always_ff @(posedge i_clk) begin
        if (n_rdy1) begin
            r_prod1 <= n_prod;
        end
        if (n_rdy2) begin
            r_ctl2 <= n_ctl2;
            r_f2   <= n_t[FW-1:0];
        end
        if (n_rdy3) begin
            r_ctl3 <= r_ctl2;
            r_f3   <= r_f2;
            r_rom3 <= w_rom[r_f2[FW-1 -: IB]];
        end
        if (n_rdy4) begin
            r_ctl4 <= r_ctl3;
            r_p4   <= n_p;
        end
        if (n_rdy5) begin
            r_bits5 <= n_bits;
            r_ovf5  <= n_ovf;
            r_unf5  <= n_unf;
        end
    end

    assign o_out.valid          = r_v5;
    assign o_out.result_bits    = r_bits5;
    assign o_out.overflow_flag  = r_ovf5;
    assign o_out.underflow_flag = r_unf5;

endmodule

`default_nettype wire

// File: rtl/fexp_pack.sv
`default_nettype none

module fexp_pack #(
    parameter int ADJUST_FRAC_BITS = fexp_pkg::ADJUST_FRAC_BITS_DEF
) (
    input  wire logic [ADJUST_FRAC_BITS+21:0] i_p,
    input  wire fexp_pkg::t_ctl               i_ctl,
    output logic [63:0]                       o_result_bits,
    output logic                              o_overflow,
    output logic                              o_underflow
);

    localparam int TOP = ADJUST_FRAC_BITS + 21;

    logic [fexp_pkg::MANT_W-1:0] n_mant;
    logic [11:0]                 n_expo;

    // leading one sits at one of three places: factor lies in 0.98 .. 1.05
    always_comb begin
        if (i_p[TOP]) begin
            n_mant = fexp_pkg::MANT_W'(64'(i_p) << (52 - TOP));
            n_expo = {1'b0, i_ctl.expo} + 12'd1;
        end else if (i_p[TOP-1]) begin
            n_mant = fexp_pkg::MANT_W'(64'(i_p) << (53 - TOP));
            n_expo = {1'b0, i_ctl.expo};
        end else begin
            n_mant = fexp_pkg::MANT_W'(64'(i_p) << (54 - TOP));
            n_expo = {1'b0, i_ctl.expo} - 12'd1;
        end
    end

    always_comb begin
        o_result_bits = fexp_pkg::RES_ZERO;
        o_overflow    = 1'b0;
        o_underflow   = 1'b0;
        unique case (i_ctl.kind)
            fexp_pkg::KIND_INF: begin
                o_result_bits = fexp_pkg::RES_INF;
                o_overflow    = 1'b1;
            end
            fexp_pkg::KIND_ZERO: begin
                o_underflow = 1'b1;
            end
            fexp_pkg::KIND_NORM: begin
                if (n_expo >= fexp_pkg::EXPO_MAX) begin
                    o_result_bits = fexp_pkg::RES_INF;
                    o_overflow    = 1'b1;
                end else if (n_expo == 12'd0) begin
                    o_underflow = 1'b1;
                end else begin
                    o_result_bits = {1'b0, n_expo[10:0], n_mant};
                end
            end
            default: begin
                o_underflow = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/fexp_chk.sv
`default_nettype none

module fexp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_result_bits,
    input wire logic        i_overflow_flag,
    input wire logic        i_underflow_flag
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_bits))
        else $error("stalled item changed");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_overflow_flag && i_underflow_flag))
        else $error("both flags raised");

    a_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow_flag |-> i_result_bits == fexp_pkg::RES_INF)
        else $error("overflow without infinity");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_underflow_flag |-> i_result_bits == fexp_pkg::RES_ZERO)
        else $error("underflow without zero");

    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_overflow_flag && !i_underflow_flag |->
            !i_result_bits[63] && i_result_bits[62:52] != 11'h7FF
            && i_result_bits[62:52] != 11'h000)
        else $error("normal result out of range");

endmodule

bind fast_exp_table_corrected fexp_chk u_fexp_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_result_bits    (o_out.result_bits),
    .i_overflow_flag  (o_out.overflow_flag),
    .i_underflow_flag (o_out.underflow_flag)
);

`default_nettype wire

// File: test/tb_fast_exp_table_corrected.sv
`default_nettype none

module tb_fast_exp_table_corrected;

    localparam int      FRAC_IN     = 20;
    localparam int      CORR_FRAC   = 23;
    localparam int      MANT_LO     = 20;
    localparam longint  SCALE       = 64'sd1512775;
    localparam longint  BIAS_SCALED = 64'sd1072632447 <<< FRAC_IN;
    localparam longint unsigned DEC_UNIT  = 64'd1000000000;
    localparam longint unsigned T_SAT     = 64'h7FF0_0000;
    localparam logic [63:0]     INF_BITS  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0]     ZERO_BITS = 64'h0;
    localparam int      EXP_MAX     = 'h7FF;
    localparam int      WAIT_MAX    = 18;
    localparam int      N_RANDOM    = 1300;
    localparam int      DRAIN_WAIT  = 10;
    localparam int      STUCK_LIMIT = 1000;

    // correction factors in units of 1e-9
    localparam int unsigned CORR_DEC [256] = '{
        1040389835, 1039159306, 1037945888, 1036749401, 1035569671, 1034406528, 1033259801,
        1032129324, 1031014933, 1029916467, 1028833767, 1027766676, 1026715040, 1025678708,
        1024657530, 1023651359, 1022660049, 1021683458, 1020721446, 1019773873, 1018840604,
        1017921503, 1017016438, 1016125279, 1015247897, 1014384165, 1013533958, 1012697153,
        1011873629, 1011063266, 1010265947, 1009481555, 1008709975, 1007951096, 1007204805,
        1006470993, 1005749552, 1005040376, 1004343358, 1003658397, 1002985389, 1002324233,
        1001674831, 1001037085, 1000410897,  999796173,  999192819,  998600742,  998019851,
         997450055,  996891266,  996343396,  995806358,  995280068,  994764440,  994259393,
         993764844,  993280711,  992806917,  992343381,  991890026,  991446776,  991013555,
         990590289,  990176903,  989773325,  989379484,  988995309,  988620729,  988255677,
         987900083,  987553882,  987217006,  986889390,  986570970,  986261682,  985961463,
         985670251,  985387985,  985114604,  984850048,  984594259,  984347178,  984108748,
         983878911,  983657613,  983444797,  983240409,  983044394,  982856701,  982677276,
         982506066,  982343022,  982188091,  982041225,  981902373,  981771487,  981648519,
         981533421,  981426146,  981326648,  981234880,  981150798,  981074356,  981005511,
         980944219,  980890437,  980844122,  980805232,  980773726,  980749562,  980732700,
         980723100,  980720722,  980725528,  980737478,  980756534,  980782660,  980815817,
         980855968,  980903079,  980955475,  981017942,  981085714,  981160303,  981241675,
         981329796,  981424634,  981526154,  981634325,  981749114,  981870489,  981998419,
         982132873,  982273820,  982421229,  982575072,  982735318,  982901937,  983074902,
         983254183,  983439752,  983631582,  983829644,  984033912,  984244358,  984460956,
         984683681,  984912505,  985147403,  985388349,  985635320,  985888290,  986147234,
         986412128,  986682949,  986959673,  987242277,  987530737,  987825031,  988125136,
         988431030,  988742691,  989060098,  989383229,  989712063,  990046579,  990386756,
         990732574,  991084012,  991441052,  991803672,  992171854,  992545578,  992924825,
         993309578,  993699816,  994095522,  994496677,  994903265,  995315266,  995732665,
         996155442,  996583582,  997017068,  997455883,  997900010,  998349434,  998804138,
         999264107,  999729325, 1000199776, 1000675446, 1001156319, 1001642381, 1002133617,
        1002630011, 1003131551, 1003638222, 1004150010, 1004666901, 1005188881, 1005715938,
        1006248058, 1006785227, 1007327434, 1007874665, 1008426907, 1008984149, 1009546377,
        1010113581, 1010685747, 1011262865, 1011844922, 1012431907, 1013023808, 1013620615,
        1014222317, 1014828902, 1015440360, 1016056681, 1016677853, 1017303866, 1017934711,
        1018570378, 1019210855, 1019856135, 1020506206, 1021161060, 1021820687, 1022485078,
        1023154224, 1023828116, 1024506745, 1025190103, 1025878180, 1026570969, 1027268461,
        1027970647, 1028677520, 1029389072, 1030114973, 1030826088, 1031551630, 1032281819,
        1033016650, 1033756114, 1034500204, 1035248913, 1036002235, 1036760162, 1037522688,
        1038289806, 1039061509, 1039837792, 1040618648
    };

    typedef struct packed {
        logic [31:0] x;
        logic [63:0] bits;
        logic        ovf;
        logic        unf;
    } t_exp_res;

    typedef struct packed {
        logic        typed;
        logic [31:0] x;
        logic [63:0] bits;
        logic        ovf;
        logic        unf;
    } t_arg_row;

    localparam int N_DIR = 20;
    localparam t_arg_row ARG_ROWS [N_DIR] = '{
        '{1'b1, 32'h8000_0000, ZERO_BITS, 1'b0, 1'b1},
        '{1'b1, 32'h7FFF_FFFF, INF_BITS,  1'b1, 1'b0},
        '{1'b1, 32'hC000_0000, ZERO_BITS, 1'b0, 1'b1},
        '{1'b1, 32'h4000_0000, INF_BITS,  1'b1, 1'b0},
        '{1'b1, 32'hAAAA_AAAA, ZERO_BITS, 1'b0, 1'b1},
        '{1'b1, 32'h5555_5555, INF_BITS,  1'b1, 1'b0},
        '{1'b0, 32'h0000_0000, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, 32'h0000_0001, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, 32'hFFFF_FFFF, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, 32'h0010_0000, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, 32'hFFF0_0000, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, 32'h0000_ABCD, ZERO_BITS, 1'b0, 1'b0},
        // sum just above and just below zero
        '{1'b0, -32'sd743492350, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, -32'sd743492351, ZERO_BITS, 1'b0, 1'b0},
        // exponent field zero and one, then field one again with a mid-range fraction
        '{1'b0, -32'sd742765533, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, -32'sd742765532, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, -32'sd742424842, ZERO_BITS, 1'b0, 1'b0},
        // top exponent field: normal, overflow through the correction, saturation
        '{1'b0, 32'sd743920000, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, 32'sd744303456, ZERO_BITS, 1'b0, 1'b0},
        '{1'b0, 32'sd744303457, ZERO_BITS, 1'b0, 1'b0}
    };

    logic     i_clk;
    logic     i_rst_n;
    t_arg_row arg_hint;

    t_exp_res pending_exp [$];
    int       fail_count;
    int       stuck_cycles;
    int       sent_items;
    int       taken_items;
    bit       calm_in;
    bit       calm_out;

    fexp_in_if  in_ch ();
    fexp_out_if out_ch ();

    fast_exp_table_corrected u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned corr_factor(input int idx);
        longint unsigned v;
        v = longint'(CORR_DEC[idx]);
        return ((v << (CORR_FRAC + 1)) + DEC_UNIT) / (2 * DEC_UNIT);
    endfunction

    function automatic t_exp_res exp_approx(input logic [31:0] x);
        t_exp_res        r;
        longint          s;
        longint unsigned t;
        longint unsigned p;
        longint unsigned m;
        int              e;
        int              idx;
        int              h;
        int              big_e;
        r.x    = x;
        r.bits = ZERO_BITS;
        r.ovf  = 1'b0;
        r.unf  = 1'b1;
        s = longint'(signed'(x)) * SCALE + BIAS_SCALED;
        if (s < 0) begin
            return r;
        end
        t = longint'(s) >> FRAC_IN;
        if (t >= T_SAT) begin
            r.bits = INF_BITS;
            r.ovf  = 1'b1;
            r.unf  = 1'b0;
            return r;
        end
        e = int'((t >> MANT_LO) & 64'h7FF);
        if (e == 0) begin
            return r;
        end
        idx = int'((t >> (MANT_LO - 8)) & 64'hFF);
        p = ((64'd1 << MANT_LO) | (t & 64'hF_FFFF)) * corr_factor(idx);
        if (p == 0) begin
            return r;
        end
        h = 63;
        while (h > 0 && ((p >> h) & 64'd1) == 0) begin
            h--;
        end
        m = (h >= 52) ? (p >> (h - 52)) : (p << (52 - h));
        big_e = e + h - MANT_LO - CORR_FRAC;
        if (big_e >= EXP_MAX) begin
            r.bits = INF_BITS;
            r.ovf  = 1'b1;
            r.unf  = 1'b0;
        end else if (big_e > 0) begin
            r.bits = (longint'(big_e) << 52) | (m & 64'h000F_FFFF_FFFF_FFFF);
            r.unf  = 1'b0;
        end
        return r;
    endfunction

    // argument whose exponent field lands on e, random fraction, small jitter
    function automatic logic [31:0] arg_for_field(input int e, input int jitter);
        longint t;
        longint v;
        t = (longint'(e) << MANT_LO) | longint'($urandom_range(0, 'hF_FFFF));
        v = ((t <<< FRAC_IN) - BIAS_SCALED) / SCALE + jitter;
        return v[31:0];
    endfunction

    task automatic send_arg(input logic [31:0] x, input t_arg_row hint);
        int gap;
        if (sent_items % 40 == 0) begin
            calm_in = ($urandom_range(0, 3) == 0);
        end
        gap = calm_in ? 0 : $urandom_range(0, WAIT_MAX);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.x_value <= x;
        arg_hint      <= hint;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_items++;
    endtask

    // result side: random back-pressure per item
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        forever begin
            if (taken_items % 50 == 0) begin
                calm_out = ($urandom_range(0, 3) == 0);
            end
            stall = calm_out ? 0 : $urandom_range(0, WAIT_MAX);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            taken_items++;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_exp_res want;
        if (out_ch.valid && out_ch.ready) begin
            if (pending_exp.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected item: bits %h ovf %b unf %b", out_ch.result_bits,
                             out_ch.overflow_flag, out_ch.underflow_flag);
                end
                fail_count++;
            end else begin
                want = pending_exp.pop_front();
                if (out_ch.result_bits !== want.bits || out_ch.overflow_flag !== want.ovf ||
                        out_ch.underflow_flag !== want.unf) begin
                    if (fail_count < 10) begin
                        $display("x %h: bits exp %h got %h, ovf exp %b got %b, unf exp %b got %b",
                                 want.x, want.bits, out_ch.result_bits, want.ovf,
                                 out_ch.overflow_flag, want.unf, out_ch.underflow_flag);
                    end
                    fail_count++;
                end
            end
        end
        if (in_ch.valid && in_ch.ready) begin
            if (arg_hint.typed) begin
                want.x    = in_ch.x_value;
                want.bits = arg_hint.bits;
                want.ovf  = arg_hint.ovf;
                want.unf  = arg_hint.unf;
            end else begin
                want = exp_approx(in_ch.x_value);
            end
            pending_exp.push_back(want);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : arg_source
        logic [31:0] x;
        int          sel;
        int          e;
        fail_count   = 0;
        stuck_cycles = 0;
        sent_items   = 0;
        taken_items  = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.x_value <= '0;
        arg_hint      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            send_arg(ARG_ROWS[i].x, ARG_ROWS[i]);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                x = $urandom;
            end else if (sel < 8) begin
                x = arg_for_field($urandom_range(1, EXP_MAX - 1), 0);
            end else begin
                case ($urandom_range(0, 5))
                    0: e = 0;
                    1: e = 1;
                    2: e = 2;
                    3: e = EXP_MAX - 2;
                    4: e = EXP_MAX - 1;
                    default: e = EXP_MAX;
                endcase
                x = arg_for_field(e, $urandom_range(0, 6) - 3);
            end
            send_arg(x, '0);
        end
        in_ch.valid <= 1'b0;

        while (pending_exp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_exp.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
